FILE: rtl/core/ipb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipb_pkg
// Shared types, constants and decode helpers for the instruction prefetch
// buffer: item and result bundles, boot address, cached window size.
// ----------------------------------------------------------------------------
package ipb_pkg;

	// Default depth of the address / word queues
	localparam int unsigned DEF_BUF_DEPTH = 4;

	// Address loaded into the head entry on reset and restart
	localparam logic [31:0] BOOT_ADDRESS = 32'h1000_0000;

	// Size of the cached window, measured from the boot address
	localparam logic [31:0] CACHED_SIZE = 32'h0800_0000;

	// Opcodes that stop prefetching until resolved
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_JAL    = 7'h6F;

	// One input transaction: the core and memory strobes sampled together
	typedef struct packed {
		logic        restart;
		logic        advance;
		logic        take_jump;
		logic [31:0] target_address;
		logic        drain;
		logic        mem_ack;
		logic [31:0] mem_word;
		logic        mem_exec_ok;
		logic        mem_user_ok;
		logic        paging_on;
	} item_t;

	// One result transaction: the registered outputs after the step
	typedef struct packed {
		logic [31:0] head_word;
		logic        head_valid;
		logic [31:0] head_address;
		logic [31:0] next_address;
		logic        next_valid;
		logic        head_exec_ok;
		logic        head_user_ok;
		logic        read_request;
		logic [31:0] read_address;
		logic        read_direct;
		logic        read_paging;
	} result_t;

	// Control-flow opcode check on the low seven bits
	function automatic logic is_branch_op(input logic [31:0] word);
		logic [6:0] op;
		op = word[6:0];
		return (op == OP_BRANCH) || (op == OP_JALR) || (op == OP_JAL);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ipb_fetch_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipb_fetch_ctrl
// Prefetch queues, counters and read request state. One step per accepted
// transaction; the result is built from the next-state values.
// ----------------------------------------------------------------------------
module ipb_fetch_ctrl #(
	parameter int unsigned BUF_DEPTH = ipb_pkg::DEF_BUF_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire ipb_pkg::item_t  item,
	input  wire logic            cache_en,
	output ipb_pkg::result_t     res
);

	localparam int CW = $clog2(BUF_DEPTH + 1);

	// State registers
	logic [31:0]   addr_q [BUF_DEPTH];
	logic [31:0]   word_q [BUF_DEPTH];
	logic          xok_q  [BUF_DEPTH];
	logic          uok_q  [BUF_DEPTH];
	logic [31:0]   tail_q;
	logic [CW-1:0] wcnt_q;
	logic [CW-1:0] acnt_q;
	logic          ack_seen_q;
	logic          discard_q;
	logic          req_q;
	logic [31:0]   raddr_q;

	// Next-state values
	logic [31:0]   addr_d [BUF_DEPTH];
	logic [31:0]   word_d [BUF_DEPTH];
	logic          xok_d  [BUF_DEPTH];
	logic          uok_d  [BUF_DEPTH];
	logic [31:0]   tail_d;
	logic [CW-1:0] wcnt_d;
	logic [CW-1:0] acnt_d;
	logic          discard_d;
	logic          req_d;
	logic [31:0]   raddr_d;
	logic          fresh;
	logic          pend_jump;

	// Single-pass next-state logic
	always_comb begin
		addr_d    = addr_q;
		word_d    = word_q;
		xok_d     = xok_q;
		uok_d     = uok_q;
		tail_d    = tail_q;
		wcnt_d    = wcnt_q;
		acnt_d    = acnt_q;
		discard_d = discard_q;
		req_d     = req_q;
		raddr_d   = raddr_q;
		fresh     = ack_seen_q && !discard_q;

		// extend the predicted address queue by one entry
		if (acnt_d < CW'(BUF_DEPTH)) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				if (CW'(i) == acnt_d) addr_d[i] = tail_q + 32'd4;
			end
			tail_d = tail_q + 32'd4;
			acnt_d = acnt_d + CW'(1);
		end

		// jump: keep head, redirect prediction to the target
		if (item.take_jump) begin
			if (wcnt_d != '0) wcnt_d = CW'(1);
			addr_d[1] = item.target_address;
			tail_d    = item.target_address;
			acnt_d    = CW'(2);
			discard_d = req_q;
		end

		// core consumed head: shift all queues, last entry holds
		if (item.advance) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++) begin
				word_d[i] = word_d[i+1];
				addr_d[i] = addr_d[i+1];
				xok_d[i]  = xok_d[i+1];
				uok_d[i]  = uok_d[i+1];
			end
			if (wcnt_d != '0) wcnt_d = wcnt_d - CW'(1);
			if (acnt_d != '0) acnt_d = acnt_d - CW'(1);
		end

		// store returned word unless stale, jumping, draining or queue full
		if (fresh && !item.take_jump && !item.drain && wcnt_d < CW'(BUF_DEPTH)) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				if (CW'(i) == wcnt_d) begin
					word_d[i] = item.mem_word;
					xok_d[i]  = item.mem_exec_ok;
					uok_d[i]  = item.mem_user_ok;
				end
			end
			wcnt_d = wcnt_d + CW'(1);
		end
		if (ack_seen_q) discard_d = 1'b0;

		// issue a new read when an address and a slot are free, not draining, no read outstanding, no jump pending
		pend_jump = (fresh && ipb_pkg::is_branch_op(item.mem_word)) ||
			(wcnt_d != '0 && ipb_pkg::is_branch_op(word_d[0]));
		if (!item.drain && !req_q && acnt_d > wcnt_d && wcnt_d < CW'(BUF_DEPTH)
			&& !pend_jump) begin
			req_d = 1'b1;
			for (int i = 0; i < BUF_DEPTH; i++) begin
				if (CW'(i) == wcnt_d) raddr_d = addr_d[i];
			end
		end

		// flush keeps only the head
		if (item.drain) begin
			wcnt_d    = CW'(1);
			discard_d = req_q;
		end

		if (item.mem_ack) req_d = 1'b0;

		// restart dominates
		if (item.restart) begin
			wcnt_d = '0;
			for (int i = 0; i < BUF_DEPTH; i++) begin
				word_d[i] = '0;
				xok_d[i]  = 1'b0;
				uok_d[i]  = 1'b0;
			end
			addr_d[0] = ipb_pkg::BOOT_ADDRESS;
			tail_d    = ipb_pkg::BOOT_ADDRESS;
			acnt_d    = CW'(1);
			req_d     = 1'b0;
			discard_d = 1'b0;
		end
	end

	// Result bundle from next-state values
	always_comb begin
		res.head_word    = word_d[0];
		res.head_valid   = (wcnt_d != '0);
		res.head_address = addr_d[0];
		res.next_address = addr_d[1];
		res.next_valid   = (acnt_d > CW'(1));
		res.head_exec_ok = xok_d[0];
		res.head_user_ok = uok_d[0];
		res.read_request = req_d;
		res.read_address = raddr_d;
		res.read_direct  = !cache_en ||
			!((raddr_d ^ ipb_pkg::BOOT_ADDRESS) < ipb_pkg::CACHED_SIZE);
		res.read_paging  = item.paging_on;
	end

	// State update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				addr_q[i] <= (i == 0) ? ipb_pkg::BOOT_ADDRESS : 32'd0;
				word_q[i] <= '0;
				xok_q[i]  <= 1'b0;
				uok_q[i]  <= 1'b0;
			end
			tail_q     <= ipb_pkg::BOOT_ADDRESS;
			wcnt_q     <= '0;
			acnt_q     <= CW'(1);
			ack_seen_q <= 1'b0;
			discard_q  <= 1'b0;
			req_q      <= 1'b0;
			raddr_q    <= '0;
		end else if (step) begin
			addr_q     <= addr_d;
			word_q     <= word_d;
			xok_q      <= xok_d;
			uok_q      <= uok_d;
			tail_q     <= tail_d;
			wcnt_q     <= wcnt_d;
			acnt_q     <= acnt_d;
			ack_seen_q <= item.mem_ack;
			discard_q  <= discard_d;
			req_q      <= req_d;
			raddr_q    <= raddr_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ipb_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipb_out_buf
// Two-entry result buffer: output register plus skid register, so a new
// transaction is taken while a finished result waits.
// ----------------------------------------------------------------------------
module ipb_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire ipb_pkg::result_t  push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output ipb_pkg::result_t       pop_data
);

	logic             out_v_q;
	logic             skid_v_q;
	ipb_pkg::result_t out_q;
	ipb_pkg::result_t skid_q;
	logic             push;
	logic             pop;

	assign push_ready = !skid_v_q;
	assign push       = push_valid && push_ready;
	assign pop        = out_v_q && pop_ready;
	assign pop_valid  = out_v_q;
	assign pop_data   = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (out_v_q && !pop_ready) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (pop) begin
			if (skid_v_q) skid_v_q <= 1'b0;
			else out_v_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (push) begin
			if (out_v_q && !pop_ready) skid_q <= push_data;
			else out_q <= push_data;
		end else if (pop && skid_v_q) begin
			out_q <= skid_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/instruction_prefetch_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// instruction_prefetch_buffer_unit
// Instruction prefetch buffer: predicted address queue, fetched word queue,
// single outstanding memory read, registered result per cycle transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one core cycle. The unit takes one transaction
// per clock while in_ready is high; its result is registered in the output buffer.
// The whole step (predict, jump, shift, store, issue, flush, restart) is one
// pass of logic from the state registers into the next state and the result
// register. A two-entry output buffer lets in_ready stay high while one
// result waits; in_ready drops only when two results are unclaimed.
// cfg_ready is always high; write cache_enable only while idle.
module instruction_prefetch_buffer_unit #(
	parameter int unsigned BUF_DEPTH = ipb_pkg::DEF_BUF_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	// input transaction
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	input  wire logic        advance,
	input  wire logic        take_jump,
	input  wire logic [31:0] target_address,
	input  wire logic        drain,
	input  wire logic        mem_ack,
	input  wire logic [31:0] mem_word,
	input  wire logic        mem_exec_ok,
	input  wire logic        mem_user_ok,
	input  wire logic        paging_on,
	// result transaction
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      head_word,
	output logic             head_valid,
	output logic [31:0]      head_address,
	output logic [31:0]      next_address,
	output logic             next_valid,
	output logic             head_exec_ok,
	output logic             head_user_ok,
	output logic             read_request,
	output logic [31:0]      read_address,
	output logic             read_direct,
	output logic             read_paging
);

	logic             cache_en_q;
	ipb_pkg::item_t   item;
	ipb_pkg::result_t res;
	ipb_pkg::result_t out_res;
	logic             step;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cache_en_q <= 1'b0;
		else if (cfg_valid && cfg_ready) cache_en_q <= cfg_data;
	end

	// Gather input fields
	assign item.restart        = restart;
	assign item.advance        = advance;
	assign item.take_jump      = take_jump;
	assign item.target_address = target_address;
	assign item.drain          = drain;
	assign item.mem_ack        = mem_ack;
	assign item.mem_word       = mem_word;
	assign item.mem_exec_ok    = mem_exec_ok;
	assign item.mem_user_ok    = mem_user_ok;
	assign item.paging_on      = paging_on;

	assign step = in_valid && in_ready;

	ipb_fetch_ctrl #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item),
		.cache_en (cache_en_q),
		.res      (res)
	);

	ipb_out_buf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (res),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (out_res)
	);

	// Spread result fields
	assign head_word    = out_res.head_word;
	assign head_valid   = out_res.head_valid;
	assign head_address = out_res.head_address;
	assign next_address = out_res.next_address;
	assign next_valid   = out_res.next_valid;
	assign head_exec_ok = out_res.head_exec_ok;
	assign head_user_ok = out_res.head_user_ok;
	assign read_request = out_res.read_request;
	assign read_address = out_res.read_address;
	assign read_direct  = out_res.read_direct;
	assign read_paging  = out_res.read_paging;

endmodule
`default_nettype wire

FILE: rtl/core/ipb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipb_checker
// Port-level checks on the prefetch buffer: result flow and back-pressure.
// ----------------------------------------------------------------------------
module ipb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] head_word,
	input wire logic [31:0] read_address,
	input wire logic        read_request
);

	// An accepted transaction always yields a result next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	// Input stalls only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// A stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_word)
			&& $stable(read_address) && $stable(read_request))
		else $error("stalled result changed");

endmodule

bind instruction_prefetch_buffer_unit ipb_checker u_ipb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.head_word    (head_word),
	.read_address (read_address),
	.read_request (read_request)
);
`default_nettype wire
